[hw/rtl/mcg_pkg.sv]
// shared types, constants and calendar tables for the month grid block
package mcg_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int CELL_W  = 6;
	localparam int LEAD_W  = 3;
	localparam int CFG_IDX_W = 2;

	localparam int GRID_CELLS      = 42;
	localparam int MONTHS_PER_YEAR = 12;
	localparam int DAYS_PER_WEEK   = 7;

	// floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 43690
	localparam logic [15:0] RECIP_100   = 16'd41944;
	localparam int          RECIP_SHIFT = 22;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [CFG_IDX_W-1:0] REG_TODAY_YEAR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TODAY_MONTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TODAY_DAY   = 2'd2;

	// one classified month, handed from the front end to the cell generator
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   len;
		logic [DAY_W-1:0]   plen;
		logic [LEAD_W-1:0]  lead;
	} grid_job_t;

	// weekday offset of each month's 1st, months 1..12
	function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [2:0] r;
		unique case (m)
			4'd1:    r = 3'd0;
			4'd2:    r = 3'd3;
			4'd3:    r = 3'd2;
			4'd4:    r = 3'd5;
			4'd5:    r = 3'd0;
			4'd6:    r = 3'd3;
			4'd7:    r = 3'd5;
			4'd8:    r = 3'd1;
			4'd9:    r = 3'd4;
			4'd10:   r = 3'd6;
			4'd11:   r = 3'd2;
			4'd12:   r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
	                                                input logic leap);
		logic [DAY_W-1:0] r;
		unique case (m)
			4'd2:                    r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default:                 r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/mcg_front.sv]
// front end: takes year/month beats and works out lead cells and month lengths
module mcg_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [mcg_pkg::YEAR_W-1:0]  year,
	input  logic [mcg_pkg::MONTH_W-1:0] month,
	output logic                      job_valid,
	input  logic                      job_ready,
	output mcg_pkg::grid_job_t        job
);
	import mcg_pkg::*;

	localparam int PROD_W = YEAR_W + 16;
	localparam int Q_W    = PROD_W - RECIP_SHIFT;
	localparam int YY_W   = YEAR_W + 1;
	localparam int SUM_W  = YEAR_W + 2;

	logic                 stall;
	logic                 valid_s1, valid_s2;
	logic [YEAR_W-1:0]    y_s1, y_s2;
	logic [MONTH_W-1:0]   m_s1, m_s2;
	logic [PROD_W-1:0]    prod_s1;
	logic [SUM_W-1:0]     total_s2;
	logic [DAY_W-1:0]     len_s2, plen_s2;
	logic [MONTH_W-1:0]   m_clamp;

	logic [Q_W-1:0]       q, q_yy;
	logic [YY_W-1:0]      q100, rem_full, yy;
	logic [6:0]           rem;
	logic                 lt3, leap;
	logic [MONTH_W-1:0]   pm;
	logic [SUM_W-1:0]     total;
	logic [5:0]           fold1;
	logic [3:0]           fold2;
	logic [2:0]           wday;
	logic [LEAD_W-1:0]    lead;

	assign stall    = valid_s2 && !job_ready;
	assign in_ready = !stall;

	always_comb begin
		if (month < MONTH_JAN) begin
			m_clamp = MONTH_JAN;
		end else if (month > MONTH_DEC) begin
			m_clamp = MONTH_DEC;
		end else begin
			m_clamp = month;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: reciprocal multiply for the century count
	always_ff @(posedge clk) begin
		if (!stall && in_valid) begin
			y_s1    <= year;
			m_s1    <= m_clamp;
			prod_s1 <= PROD_W'(year) * PROD_W'(RECIP_100);
		end
	end

	// stage 2 inputs: leap year, lengths and the weekday sum
	always_comb begin
		q        = prod_s1[PROD_W-1:RECIP_SHIFT];
		q100     = YY_W'(q) * YY_W'(100);
		rem_full = YY_W'(y_s1) - q100;
		rem      = rem_full[6:0];
		leap     = (y_s1[1:0] == 2'd0) && ((rem != 7'd0) || (q[1:0] == 2'd0));
		lt3      = m_s1 < MONTH_MAR;
		// shifted year is y + 400, minus one for january and february
		yy       = YY_W'(y_s1) + YY_W'(400) - YY_W'(lt3);
		q_yy     = q + Q_W'(4) - Q_W'(lt3 && (rem == 7'd0));
		total    = SUM_W'(yy) + SUM_W'(yy >> 2) - SUM_W'(q_yy) + SUM_W'(q_yy >> 2)
		         + SUM_W'(month_offset(m_s1)) + SUM_W'(1);
		pm       = (m_s1 == MONTH_JAN) ? MONTH_DEC : m_s1 - MONTH_W'(1);
	end

	always_ff @(posedge clk) begin
		if (!stall && valid_s1) begin
			y_s2     <= y_s1;
			m_s2     <= m_s1;
			total_s2 <= total;
			len_s2   <= month_days(m_s1, leap);
			// previous month is february only in the same year
			plen_s2  <= month_days(pm, leap);
		end
	end

	// mod 7 by folding octal digits, since 8 is 1 mod 7
	always_comb begin
		fold1 = 6'(total_s2[2:0]) + 6'(total_s2[5:3]) + 6'(total_s2[8:6])
		      + 6'(total_s2[11:9]) + 6'(total_s2[14:12]) + 6'(total_s2[15]);
		fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
		wday  = (fold2 >= 4'(DAYS_PER_WEEK)) ? 3'(fold2 - 4'(DAYS_PER_WEEK)) : fold2[2:0];
		// weekday 0 is sunday: six leading cells
		lead  = (wday == 3'd0) ? LEAD_W'(DAYS_PER_WEEK - 1) : wday - 3'd1;
	end

	assign job_valid  = valid_s2;
	assign job.year   = y_s2;
	assign job.month  = m_s2;
	assign job.len    = len_s2;
	assign job.plen   = plen_s2;
	assign job.lead   = lead;

endmodule

[hw/rtl/mcg_queue.sv]
// small job queue between the front end and the cell generator
module mcg_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  mcg_pkg::grid_job_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output mcg_pkg::grid_job_t pop_data
);
	import mcg_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	grid_job_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push, pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != CNT_W'(0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[hw/rtl/mcg_back.sv]
// back end: walks the 42 grid cells of one job, one output beat per cycle while out_ready holds
module mcg_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	output logic                        job_ready,
	input  mcg_pkg::grid_job_t          job,
	input  logic [mcg_pkg::YEAR_W-1:0]  today_year,
	input  logic [mcg_pkg::MONTH_W-1:0] today_month,
	input  logic [mcg_pkg::DAY_W-1:0]   today_day,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mcg_pkg::DAY_W-1:0]   day,
	output logic                        in_month,
	output logic                        is_today,
	output logic                        last
);
	import mcg_pkg::*;

	localparam int YY_W = YEAR_W + 1;

	grid_job_t          job_q;
	logic               active_q, out_valid_q;
	logic [CELL_W-1:0]  k_q;
	logic [DAY_W-1:0]   day_q;
	logic               in_month_q, is_today_q, last_q;

	logic               adv, last_cell;
	logic [CELL_W-1:0]  lead6, lim2;
	logic [YY_W-1:0]    py, ny, cell_year;
	logic [MONTH_W-1:0] pm, nm, cell_month;
	logic [CELL_W-1:0]  cell_day6;
	logic [DAY_W-1:0]   cell_day;
	logic               cell_in_month, cell_today;

	assign adv       = !out_valid_q || out_ready;
	assign last_cell = k_q == CELL_W'(GRID_CELLS - 1);
	assign job_ready = job_valid && (!active_q || (adv && last_cell));

	always_comb begin
		lead6 = CELL_W'(job_q.lead);
		lim2  = lead6 + CELL_W'(job_q.len);
		// year -1 and year 16384 get bit 14 set and never match today
		py    = (job_q.month == MONTH_JAN) ? YY_W'(job_q.year) - YY_W'(1) : YY_W'(job_q.year);
		pm    = (job_q.month == MONTH_JAN) ? MONTH_DEC : job_q.month - MONTH_W'(1);
		ny    = (job_q.month == MONTH_DEC) ? YY_W'(job_q.year) + YY_W'(1) : YY_W'(job_q.year);
		nm    = (job_q.month == MONTH_DEC) ? MONTH_JAN : job_q.month + MONTH_W'(1);
		if (k_q < lead6) begin
			cell_day6     = CELL_W'(job_q.plen) - lead6 + CELL_W'(1) + k_q;
			cell_year     = py;
			cell_month    = pm;
			cell_in_month = 1'b0;
		end else if (k_q < lim2) begin
			cell_day6     = k_q - lead6 + CELL_W'(1);
			cell_year     = YY_W'(job_q.year);
			cell_month    = job_q.month;
			cell_in_month = 1'b1;
		end else begin
			cell_day6     = k_q - lim2 + CELL_W'(1);
			cell_year     = ny;
			cell_month    = nm;
			cell_in_month = 1'b0;
		end
		cell_day   = cell_day6[DAY_W-1:0];
		cell_today = (cell_year == YY_W'(today_year)) && (cell_month == today_month)
		          && (cell_day == today_day);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= active_q;
			end
			if (job_ready) begin
				active_q <= 1'b1;
				k_q      <= '0;
			end else if (adv && active_q) begin
				k_q <= k_q + CELL_W'(1);
				if (last_cell) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready) begin
			job_q <= job;
		end
		if (adv && active_q) begin
			day_q      <= cell_day;
			in_month_q <= cell_in_month;
			is_today_q <= cell_today;
			last_q     <= last_cell;
		end
	end

	assign out_valid = out_valid_q;
	assign day       = day_q;
	assign in_month  = in_month_q;
	assign is_today  = is_today_q;
	assign last      = last_q;

endmodule

[hw/rtl/month_calendar_grid.sv]
// top level of the six-week monday-first month grid generator
//
//   channel  signals                                 direction  beat
//   in       in_valid/in_ready, year, month          input      one month request
//   out      out_valid/out_ready, day, in_month,     output     one grid cell
//            is_today, last
//   cfg      cfg_we, cfg_index, cfg_data             input      one register write
//
// each request gives 42 output beats, one per cycle while out_ready holds;
// the cell counter in the back end sets that figure, and the back end takes
// the next month from the queue as it registers the last cell of the previous one.
// the front end registers each request in its s1 and s2 stages ahead of the job queue.
// reset is asynchronous and clears all control state plus today = 2000-01-01.
// a stalled output keeps the front end working until the queue fills.
module month_calendar_grid #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mcg_pkg::YEAR_W-1:0]    year,
	input  logic [mcg_pkg::MONTH_W-1:0]   month,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mcg_pkg::DAY_W-1:0]     day,
	output logic                          in_month,
	output logic                          is_today,
	output logic                          last,
	input  logic                          cfg_we,
	input  logic [mcg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcg_pkg::YEAR_W-1:0]    cfg_data
);
	import mcg_pkg::*;

	logic [YEAR_W-1:0]  today_year_q;
	logic [MONTH_W-1:0] today_month_q;
	logic [DAY_W-1:0]   today_day_q;

	logic      fj_valid, fj_ready, bj_valid, bj_ready;
	grid_job_t fj_data, bj_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			today_year_q  <= YEAR_W'(2000);
			today_month_q <= MONTH_W'(1);
			today_day_q   <= DAY_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TODAY_YEAR:  today_year_q  <= cfg_data;
				REG_TODAY_MONTH: today_month_q <= cfg_data[MONTH_W-1:0];
				REG_TODAY_DAY:   today_day_q   <= cfg_data[DAY_W-1:0];
				default: ;
			endcase
		end
	end

	mcg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.year      (year),
		.month     (month),
		.job_valid (fj_valid),
		.job_ready (fj_ready),
		.job       (fj_data)
	);

	mcg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fj_valid),
		.push_ready (fj_ready),
		.push_data  (fj_data),
		.pop_valid  (bj_valid),
		.pop_ready  (bj_ready),
		.pop_data   (bj_data)
	);

	mcg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (bj_valid),
		.job_ready   (bj_ready),
		.job         (bj_data),
		.today_year  (today_year_q),
		.today_month (today_month_q),
		.today_day   (today_day_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.day         (day),
		.in_month    (in_month),
		.is_today    (is_today),
		.last        (last)
	);

endmodule
